// File: rtl/core/assert_macros.svh
// Assertion macros shared by the files that check the vertex generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CAV_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define CAV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cav_pkg.sv
// Types, constants and tables shared by the vertex generator modules.
package cav_pkg;

	localparam int SEGMENTS     = 32;
	localparam int FULL_DEG64   = 23040;
	localparam int CORDIC_STEPS = 30;
	localparam int DIV_STEPS    = 32;
	localparam int MUL_STEPS    = 4;
	localparam int CNT_W        = $clog2(SEGMENTS + 2);
	localparam int DEN_W        = $clog2(SEGMENTS * FULL_DEG64 + 1);
	localparam int REM_W        = DEN_W + 1;
	localparam int SDM_W        = $clog2(FULL_DEG64);
	localparam int CRD_W        = 34;
	localparam int ITER_W       = 5;
	localparam int STEP_W       = 6;
	localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

	localparam logic [2:0] MODE_ARC    = 3'd0;
	localparam logic [2:0] MODE_FARC   = 3'd1;
	localparam logic [2:0] MODE_CIRC   = 3'd2;
	localparam logic [2:0] MODE_FCIRC  = 3'd3;
	localparam logic [2:0] MODE_WASHER = 3'd4;
	localparam logic [2:0] MODE_RECT   = 3'd5;
	localparam logic [2:0] MODE_MOVE   = 3'd6;
	localparam logic [2:0] MODE_DRAW   = 3'd7;

	localparam logic [2:0] PRIM_LSTRIP = 3'd0;
	localparam logic [2:0] PRIM_TFAN   = 3'd1;
	localparam logic [2:0] PRIM_LLOOP  = 3'd2;
	localparam logic [2:0] PRIM_POLY   = 3'd3;
	localparam logic [2:0] PRIM_TSTRIP = 3'd4;
	localparam logic [2:0] PRIM_SINGLE = 3'd5;

	typedef struct packed {
		logic              latch;
		logic              ncalc_step;
		logic              init_arc;
		logic              div_step;
		logic              div_first;
		logic              cordic_init;
		logic              cordic_step;
		logic [ITER_W-1:0] iter;
		logic              mul_go;
		logic [1:0]        mul_idx;
		logic              load_direct;
		logic [1:0]        direct_k;
		logic              load_point;
		logic              last;
		logic              advance;
	} cav_cmd_t;

	typedef struct packed {
		logic             slot_free;
		logic             span_neg;
		logic             acc_ge;
		logic [CNT_W-1:0] n;
	} cav_stat_t;

	function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/cav_cmd_if.sv
// Handshake channel that carries one drawing command item.
interface cav_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [23:0] x;
	logic signed [23:0] y;
	logic signed [23:0] param_a;
	logic signed [23:0] param_b;
	logic signed [15:0] start_deg;
	logic signed [15:0] end_deg;

	modport source (output valid, mode, x, y, param_a, param_b, start_deg, end_deg,
		input ready);
	modport sink (input valid, mode, x, y, param_a, param_b, start_deg, end_deg,
		output ready);
endinterface

// File: rtl/core/cav_vtx_if.sv
// Handshake channel that carries one vertex item.
interface cav_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] vert_x;
	logic signed [23:0] vert_y;
	logic signed [23:0] outer_x;
	logic signed [23:0] outer_y;
	logic [2:0]         prim_kind;
	logic               last;

	modport source (output valid, vert_x, vert_y, outer_x, outer_y, prim_kind, last,
		input ready);
	modport sink (input valid, vert_x, vert_y, outer_x, outer_y, prim_kind, last,
		output ready);
endinterface

// File: rtl/core/cav_ctrl.sv
// Sequencer for division, rotation, scaling and output of arc and circle points.
module cav_ctrl import cav_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] in_mode,
	output logic       in_ready,
	input  cav_stat_t  stat,
	output cav_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DIRECT = 4'd1;
	localparam logic [3:0] S_NCALC  = 4'd2;
	localparam logic [3:0] S_INIT   = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_CINIT  = 4'd5;
	localparam logic [3:0] S_CORD   = 4'd6;
	localparam logic [3:0] S_MUL    = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [2:0]        mode_q, mode_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0]  pt_q, pt_d;
	logic [1:0]        k_q, k_d;
	logic [CNT_W-1:0]  npts;
	logic              pt_last;

	always_comb begin
		case (mode_q)
			MODE_CIRC, MODE_FCIRC: npts = CNT_W'(SEGMENTS);
			MODE_WASHER:           npts = CNT_W'(SEGMENTS + 1);
			default:               npts = stat.n + CNT_W'(1);
		endcase
	end

	assign pt_last = (pt_q == npts - CNT_W'(1));

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		pt_d     = pt_q;
		k_d      = k_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.iter = cnt_q[ITER_W-1:0];
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					mode_d    = in_mode;
					cnt_d     = '0;
					pt_d      = '0;
					k_d       = '0;
					case (in_mode)
						MODE_ARC:                           state_d = S_NCALC;
						MODE_CIRC, MODE_FCIRC, MODE_WASHER: state_d = S_DIV;
						default:                            state_d = S_DIRECT;
					endcase
				end
			end
			S_DIRECT: begin
				cmd.direct_k = k_q;
				if (mode_q == MODE_RECT) begin
					cmd.last = (k_q == 2'd3);
				end else if (mode_q == MODE_FARC) begin
					cmd.last = stat.span_neg;
				end else begin
					cmd.last = 1'b1;
				end
				if (stat.slot_free) begin
					cmd.load_direct = 1'b1;
					k_d = k_q + 2'd1;
					if (mode_q == MODE_FARC) begin
						state_d = stat.span_neg ? S_IDLE : S_NCALC;
					end else if (cmd.last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_NCALC: begin
				if (stat.span_neg) begin
					state_d = S_IDLE;
				end else begin
					cmd.ncalc_step = 1'b1;
					if (!stat.acc_ge) begin
						state_d = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init_arc = 1'b1;
				cnt_d        = '0;
				pt_d         = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_CINIT;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_CINIT: begin
				cmd.cordic_init = 1'b1;
				cnt_d           = '0;
				state_d         = S_CORD;
			end
			S_CORD: begin
				cmd.cordic_step = 1'b1;
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_MUL;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_MUL: begin
				cmd.mul_go  = (cnt_q < STEP_W'(MUL_STEPS));
				cmd.mul_idx = cnt_q[1:0];
				if (cnt_q == STEP_W'(MUL_STEPS)) begin
					cnt_d   = '0;
					state_d = S_OUT;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_OUT: begin
				cmd.last = pt_last;
				if (stat.slot_free) begin
					cmd.load_point = 1'b1;
					cmd.advance    = 1'b1;
					cnt_d          = '0;
					if (pt_last) begin
						state_d = S_IDLE;
					end else begin
						pt_d    = pt_q + CNT_W'(1);
						state_d = S_DIV;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_ARC;
			cnt_q   <= '0;
			pt_q    <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			pt_q    <= pt_d;
			k_q     <= k_d;
		end
	end

endmodule

// File: rtl/core/cav_dpath.sv
// Datapath with angle divider, CORDIC rotator, radius multiplier, pen and output register.
module cav_dpath import cav_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cav_cmd_t           cmd,
	output cav_stat_t          stat,
	input  logic [2:0]         in_mode,
	input  logic signed [23:0] in_x,
	input  logic signed [23:0] in_y,
	input  logic signed [23:0] in_pa,
	input  logic signed [23:0] in_pb,
	input  logic signed [15:0] in_sd,
	input  logic signed [15:0] in_ed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] out_vx,
	output logic signed [23:0] out_vy,
	output logic signed [23:0] out_ox,
	output logic signed [23:0] out_oy,
	output logic [2:0]         out_prim,
	output logic               out_last
);

	logic [2:0]         mode_q;
	logic signed [23:0] x_q, y_q, pa_q, pb_q;
	logic signed [23:0] pen_x_q, pen_y_q;
	logic [SDM_W-1:0]   span_q, sdm_q;
	logic               span_neg_q;
	logic [DEN_W-1:0]   acc_q, r_q, den_q, step_q;
	logic [CNT_W-1:0]   n_q;
	logic [REM_W-1:0]   rem_q;
	logic [31:0]        u_q;
	logic signed [CRD_W-1:0] cx_q, cy_q, z_q;
	logic               neg_q;
	logic signed [57:0] prod_s1;
	logic signed [23:0] center_s1;
	logic [1:0]         idx_s1;
	logic               valid_s1;
	logic signed [23:0] res_q [4];
	logic               out_valid_q;

	logic signed [16:0] span_full;
	logic [SDM_W-1:0]   span_c;
	logic [17:0]        v0, v1, v2, v3;
	logic signed [24:0] pen_sx, pen_sy;
	logic [CNT_W-1:0]   m_val;
	logic [REM_W-1:0]   rem_base, rem_sh;
	logic [31:0]        u_rot;
	logic               neg_c;
	logic signed [CRD_W-1:0] dx, dy, at;
	logic signed [CRD_W-1:0] tc, ts, trig_sel;
	logic signed [23:0] rad_sel, cen_sel;
	logic signed [58:0] rounded;
	logic signed [29:0] place_sum;
	logic signed [23:0] place_sat;
	logic [DEN_W:0]     r_next;
	logic [2:0]         prim;

	function automatic logic signed [23:0] sat25(input logic signed [24:0] v);
		logic signed [23:0] r;
		if (v[24] != v[23]) begin
			r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	always_comb begin
		span_full = {in_ed[15], in_ed} - {in_sd[15], in_sd};
		if (span_full > 17'sd23040) begin
			span_c = SDM_W'(FULL_DEG64);
		end else begin
			span_c = span_full[SDM_W-1:0];
		end
		v0 = {{2{in_sd[15]}}, in_sd} + 18'd46080;
		v1 = (v0 >= 18'(FULL_DEG64)) ? v0 - 18'(FULL_DEG64) : v0;
		v2 = (v1 >= 18'(FULL_DEG64)) ? v1 - 18'(FULL_DEG64) : v1;
		v3 = (v2 >= 18'(FULL_DEG64)) ? v2 - 18'(FULL_DEG64) : v2;
		pen_sx = {pen_x_q[23], pen_x_q} + {in_x[23], in_x};
		pen_sy = {pen_y_q[23], pen_y_q} + {in_y[23], in_y};
	end

	assign m_val    = (n_q == '0) ? CNT_W'(1) : n_q;
	assign rem_base = cmd.div_first ? {1'b0, r_q} : rem_q;
	assign rem_sh   = {rem_base[REM_W-2:0], 1'b0};
	assign neg_c    = u_q[31] ^ u_q[30];
	assign u_rot    = neg_c ? {~u_q[31], u_q[30:0]} : u_q;
	assign dx       = cy_q >>> cmd.iter;
	assign dy       = cx_q >>> cmd.iter;
	assign at       = $signed({2'b00, atan_turn(cmd.iter)});
	assign tc       = neg_q ? -cx_q : cx_q;
	assign ts       = neg_q ? -cy_q : cy_q;
	assign trig_sel = cmd.mul_idx[0] ? ts : tc;
	assign rad_sel  = cmd.mul_idx[1] ? pb_q : pa_q;
	assign cen_sel  = cmd.mul_idx[0] ? y_q : x_q;
	assign rounded  = {prod_s1[57], prod_s1} + 59'sd536870912;
	assign place_sum = {{6{center_s1[23]}}, center_s1} + {rounded[58], rounded[58:30]};
	assign r_next   = {1'b0, r_q} + {1'b0, step_q};

	always_comb begin
		if (place_sum > 30'sd8388607) begin
			place_sat = 24'sh7FFFFF;
		end else if (place_sum < -30'sd8388608) begin
			place_sat = 24'sh800000;
		end else begin
			place_sat = place_sum[23:0];
		end
	end

	always_comb begin
		case (mode_q)
			MODE_ARC:              prim = PRIM_LSTRIP;
			MODE_FARC:             prim = PRIM_TFAN;
			MODE_CIRC, MODE_RECT:  prim = PRIM_LLOOP;
			MODE_FCIRC:            prim = PRIM_POLY;
			MODE_WASHER:           prim = PRIM_TSTRIP;
			default:               prim = PRIM_SINGLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q     <= in_mode;
			x_q        <= in_x;
			y_q        <= in_y;
			pa_q       <= in_pa;
			pb_q       <= in_pb;
			span_q     <= span_c;
			span_neg_q <= span_full[16];
			sdm_q      <= v3[SDM_W-1:0];
			acc_q      <= DEN_W'(SEGMENTS) * DEN_W'(span_c);
			n_q        <= '0;
			r_q        <= '0;
			den_q      <= DEN_W'(SEGMENTS);
			step_q     <= DEN_W'(1);
		end
		if (cmd.ncalc_step && stat.acc_ge) begin
			acc_q <= acc_q - DEN_W'(FULL_DEG64);
			n_q   <= n_q + CNT_W'(1);
		end
		if (cmd.init_arc) begin
			r_q    <= DEN_W'(m_val) * DEN_W'(sdm_q);
			den_q  <= DEN_W'(m_val) * DEN_W'(FULL_DEG64);
			step_q <= DEN_W'(span_q);
		end
		if (cmd.div_step) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				u_q   <= {u_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				u_q   <= {u_q[30:0], 1'b0};
			end
		end
		if (cmd.cordic_init) begin
			neg_q <= neg_c;
			z_q   <= CRD_W'($signed(u_rot));
			cx_q  <= CRD_W'(CORDIC_GAIN);
			cy_q  <= '0;
		end
		if (cmd.cordic_step) begin
			if (!z_q[CRD_W-1]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + at;
			end
		end
		if (cmd.mul_go) begin
			prod_s1   <= 58'(rad_sel * trig_sel);
			center_s1 <= cen_sel;
			idx_s1    <= cmd.mul_idx;
		end
		if (valid_s1) begin
			res_q[idx_s1] <= place_sat;
		end
		if (cmd.advance) begin
			if (r_next >= {1'b0, den_q}) begin
				r_q <= DEN_W'(r_next - {1'b0, den_q});
			end else begin
				r_q <= r_next[DEN_W-1:0];
			end
		end
		if (cmd.load_point) begin
			out_vx   <= res_q[0];
			out_vy   <= res_q[1];
			out_ox   <= (mode_q == MODE_WASHER) ? res_q[2] : '0;
			out_oy   <= (mode_q == MODE_WASHER) ? res_q[3] : '0;
			out_prim <= prim;
			out_last <= cmd.last;
		end
		if (cmd.load_direct) begin
			out_ox   <= '0;
			out_oy   <= '0;
			out_prim <= prim;
			out_last <= cmd.last;
			if (mode_q == MODE_RECT) begin
				out_vx <= cmd.direct_k[0] ^ cmd.direct_k[1] ? pa_q : x_q;
				out_vy <= cmd.direct_k[1] ? pb_q : y_q;
			end else if (mode_q == MODE_FARC) begin
				out_vx <= x_q;
				out_vy <= y_q;
			end else begin
				out_vx <= pen_x_q;
				out_vy <= pen_y_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.mul_go;
			if (cmd.latch && in_mode == MODE_MOVE) begin
				pen_x_q <= in_x;
				pen_y_q <= in_y;
			end else if (cmd.latch && in_mode == MODE_DRAW) begin
				pen_x_q <= sat25(pen_sx);
				pen_y_q <= sat25(pen_sy);
			end
			if (cmd.load_point || cmd.load_direct) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.span_neg  = span_neg_q;
	assign stat.acc_ge    = (acc_q >= DEN_W'(FULL_DEG64));
	assign stat.n         = n_q;

endmodule

// File: rtl/core/circle_arc_vertex_generator.sv
// Top level of the circle, arc and polygon vertex generator.
// The cmd channel takes one drawing command item; the vtx channel gives its
// vertex items in drawing order, with last set on the final one.
// A command is taken only while the sequencer is idle; the next command is
// taken as soon as the last vertex of the previous one is in the output
// register, so a waiting vertex does not hold up the next command.
// Each arc, circle or washer vertex passes through the bit-serial angle
// divider, a setup step and the CORDIC rotator, then the shared radius
// multiplier, and is then loaded into the output register. An arc first
// computes its step count before its first vertex. Rectangle, move, draw
// and filled-arc center vertices are loaded without the divider or rotator.
// Reset clears the pen position to the origin, empties the output register
// and returns the sequencer to idle. While the receiver stalls, the output
// register holds its vertex and the sequencer waits before loading the next.
module circle_arc_vertex_generator import cav_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	cav_cmd_if.sink  cmd,
	cav_vtx_if.source vtx
);

	`include "assert_macros.svh"

	cav_cmd_t  ctl;
	cav_stat_t stat;

	cav_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_mode  (cmd.mode),
		.in_ready (cmd.ready),
		.stat     (stat),
		.cmd      (ctl)
	);

	cav_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl),
		.stat      (stat),
		.in_mode   (cmd.mode),
		.in_x      (cmd.x),
		.in_y      (cmd.y),
		.in_pa     (cmd.param_a),
		.in_pb     (cmd.param_b),
		.in_sd     (cmd.start_deg),
		.in_ed     (cmd.end_deg),
		.out_valid (vtx.valid),
		.out_ready (vtx.ready),
		.out_vx    (vtx.vert_x),
		.out_vy    (vtx.vert_y),
		.out_ox    (vtx.outer_x),
		.out_oy    (vtx.outer_y),
		.out_prim  (vtx.prim_kind),
		.out_last  (vtx.last)
	);

	`CAV_ASSERT(a_load_slot, !(ctl.load_point || ctl.load_direct) || stat.slot_free, "vertex loaded into a full output register")
	`CAV_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready, "command taken while busy")
	`CAV_ASSERT(a_one_op, $onehot0({ctl.latch, ctl.div_step, ctl.cordic_step, ctl.mul_go, ctl.load_point, ctl.load_direct}), "overlapping datapath operations")

endmodule

// File: tb/tb_circle_arc_vertex_generator.sv
// Testbench for the circle, arc and polygon vertex generator, with its own vertex predictor.
`timescale 1ns / 1ps
module tb_circle_arc_vertex_generator;
	import cav_pkg::*;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] pa;
		logic signed [23:0] pb;
		logic signed [15:0] sd;
		logic signed [15:0] ed;
	} draw_cmd_t;

	typedef struct packed {
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic signed [23:0] ox;
		logic signed [23:0] oy;
		logic [2:0]         prim;
		logic               last;
	} vertex_t;

	localparam longint ATAN_TAB [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

	logic clk;
	logic arst_n;

	cav_cmd_if cmd_ch ();
	cav_vtx_if vtx_ch ();

	circle_arc_vertex_generator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.vtx    (vtx_ch)
	);

	vertex_t   vertex_q[$];
	vertex_t   scratch_q[$];
	draw_cmd_t dir_cmd[$];
	int        dir_cnt[$];
	vertex_t   dir_vtx[$];
	longint    pen_x;
	longint    pen_y;
	int        send_idle;
	int        recv_idle;
	int        hold_left;
	int        mismatches;
	int        cmds_sent;
	int        verts_seen;
	int        mode_seen[8];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat24(input longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return v;
	endfunction

	function automatic void cordic_turn(input longint num, input longint den,
		output longint c, output longint s);
		longint      r;
		longint      z;
		longint      cx;
		longint      cy;
		longint      dx;
		longint      dy;
		logic [31:0] u;
		logic [31:0] t;
		logic        neg;
		r = num % den;
		if (r < 0)
			r += den;
		u = 32'((r << 32) / den);
		t = u + 32'h40000000;
		neg = 1'b0;
		if (t >= 32'h80000000) begin
			neg = 1'b1;
			u = u + 32'h80000000;
		end
		z = longint'($signed(u));
		cx = longint'(CORDIC_GAIN);
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= ATAN_TAB[i];
			end else begin
				cx += dx;
				cy -= dy;
				z += ATAN_TAB[i];
			end
		end
		c = neg ? -cx : cx;
		s = neg ? -cy : cy;
	endfunction

	function automatic longint place(input longint center, input longint radius,
		input longint t);
		return sat24(center + ((radius * t + (64'sd1 <<< 29)) >>> 30));
	endfunction

	function automatic void push_vertex(ref vertex_t q[$], input longint vx, input longint vy,
		input longint ox, input longint oy, input logic [2:0] prim);
		vertex_t v;
		v.vx = 24'(vx);
		v.vy = 24'(vy);
		v.ox = 24'(ox);
		v.oy = 24'(oy);
		v.prim = prim;
		v.last = 1'b0;
		q.push_back(v);
	endfunction

	// Expands one command into its vertices and updates the pen.
	function automatic void expand_command(input draw_cmd_t cm, ref vertex_t q[$]);
		int     first;
		longint x;
		longint y;
		longint pa;
		longint pb;
		longint sd;
		longint span;
		longint n;
		longint m;
		longint c;
		longint s;
		first = q.size();
		x = cm.x;
		y = cm.y;
		pa = cm.pa;
		pb = cm.pb;
		sd = cm.sd;
		case (cm.mode)
			MODE_ARC, MODE_FARC: begin
				span = longint'(cm.ed) - sd;
				if (span > FULL_DEG64)
					span = FULL_DEG64;
				if (cm.mode == MODE_FARC)
					push_vertex(q, x, y, 0, 0, PRIM_TFAN);
				if (span >= 0) begin
					n = (SEGMENTS * span) / FULL_DEG64;
					m = (n != 0) ? n : 1;
					for (longint i = 0; i <= n; i++) begin
						cordic_turn(sd * m + i * span, m * FULL_DEG64, c, s);
						push_vertex(q, place(x, pa, c), place(y, pa, s), 0, 0,
							(cm.mode == MODE_FARC) ? PRIM_TFAN : PRIM_LSTRIP);
					end
				end
			end
			MODE_CIRC, MODE_FCIRC: begin
				for (int i = 0; i < SEGMENTS; i++) begin
					cordic_turn(i, SEGMENTS, c, s);
					push_vertex(q, place(x, pa, c), place(y, pa, s), 0, 0,
						(cm.mode == MODE_CIRC) ? PRIM_LLOOP : PRIM_POLY);
				end
			end
			MODE_WASHER: begin
				for (int i = 0; i <= SEGMENTS; i++) begin
					cordic_turn(i, SEGMENTS, c, s);
					push_vertex(q, place(x, pa, c), place(y, pa, s),
						place(x, pb, c), place(y, pb, s), PRIM_TSTRIP);
				end
			end
			MODE_RECT: begin
				push_vertex(q, x, y, 0, 0, PRIM_LLOOP);
				push_vertex(q, pa, y, 0, 0, PRIM_LLOOP);
				push_vertex(q, pa, pb, 0, 0, PRIM_LLOOP);
				push_vertex(q, x, pb, 0, 0, PRIM_LLOOP);
			end
			default: begin
				if (cm.mode == MODE_MOVE) begin
					pen_x = x;
					pen_y = y;
				end else begin
					pen_x = sat24(pen_x + x);
					pen_y = sat24(pen_y + y);
				end
				push_vertex(q, pen_x, pen_y, 0, 0, PRIM_SINGLE);
			end
		endcase
		if (q.size() > first)
			q[q.size() - 1].last = 1'b1;
	endfunction

	function automatic draw_cmd_t mk_cmd(input logic [2:0] mode, input int x, input int y,
		input int pa, input int pb, input int sd, input int ed);
		draw_cmd_t cm;
		cm.mode = mode;
		cm.x = 24'(x);
		cm.y = 24'(y);
		cm.pa = 24'(pa);
		cm.pb = 24'(pb);
		cm.sd = 16'(sd);
		cm.ed = 16'(ed);
		return cm;
	endfunction

	function automatic vertex_t mk_vtx(input int vx, input int vy, input logic [2:0] prim,
		input logic last);
		vertex_t v;
		v.vx = 24'(vx);
		v.vy = 24'(vy);
		v.ox = '0;
		v.oy = '0;
		v.prim = prim;
		v.last = last;
		return v;
	endfunction

	// A count of -1 means the row is checked against the predictor.
	task automatic add_row(input draw_cmd_t cm, input int cnt);
		dir_cmd.push_back(cm);
		dir_cnt.push_back(cnt);
	endtask

	function automatic int coord();
		if ($urandom_range(1))
			return int'($signed(24'($urandom)));
		return $signed($urandom_range(40000)) - 20000;
	endfunction

	function automatic draw_cmd_t random_cmd();
		int        roll;
		int        sd;
		draw_cmd_t cm;
		roll = $urandom_range(99);
		cm.mode = (roll < 20) ? MODE_ARC : (roll < 35) ? MODE_FARC :
			(roll < 42) ? MODE_CIRC : (roll < 48) ? MODE_FCIRC :
			(roll < 53) ? MODE_WASHER : (roll < 68) ? MODE_RECT :
			(roll < 80) ? MODE_MOVE : MODE_DRAW;
		cm.x = 24'(coord());
		cm.y = 24'(coord());
		cm.pa = 24'(coord());
		cm.pb = 24'(coord());
		sd = int'($signed(16'($urandom)));
		cm.sd = 16'(sd);
		roll = $urandom_range(99);
		if (roll < 50)
			cm.ed = 16'(sd + int'($urandom_range(5760)));
		else if (roll < 70)
			cm.ed = 16'(sd - 1 - int'($urandom_range(5760)));
		else
			cm.ed = 16'($urandom);
		return cm;
	endfunction

	task automatic send_cmd(input draw_cmd_t cm);
		if ($urandom_range(99) < send_idle) begin
			cmd_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= cm.mode;
		cmd_ch.x <= cm.x;
		cmd_ch.y <= cm.y;
		cmd_ch.param_a <= cm.pa;
		cmd_ch.param_b <= cm.pb;
		cmd_ch.start_deg <= cm.sd;
		cmd_ch.end_deg <= cm.ed;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		cmds_sent++;
		mode_seen[cm.mode]++;
	endtask

	task automatic run_random(input int count);
		draw_cmd_t cm;
		for (int i = 0; i < count; i++) begin
			cm = random_cmd();
			send_cmd(cm);
			expand_command(cm, vertex_q);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			vtx_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			vtx_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			vtx_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		vertex_t got;
		vertex_t want;
		if (arst_n && vtx_ch.valid && vtx_ch.ready) begin
			got.vx = vtx_ch.vert_x;
			got.vy = vtx_ch.vert_y;
			got.ox = vtx_ch.outer_x;
			got.oy = vtx_ch.outer_y;
			got.prim = vtx_ch.prim_kind;
			got.last = vtx_ch.last;
			verts_seen++;
			if (vertex_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected vertex: x=%0d y=%0d ox=%0d oy=%0d prim=%0d last=%0b",
						got.vx, got.vy, got.ox, got.oy, got.prim, got.last);
			end else begin
				want = vertex_q.pop_front();
				if (got.vx !== want.vx || got.vy !== want.vy || got.ox !== want.ox ||
					got.oy !== want.oy || got.prim !== want.prim || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: want %0d %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0d %0b",
							want.vx, want.vy, want.ox, want.oy, want.prim, want.last,
							got.vx, got.vy, got.ox, got.oy, got.prim, got.last);
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("Timeout with %0d vertices outstanding.", vertex_q.size());
		$display("tb_circle_arc_vertex_generator NOT OK");
		$finish;
	end

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_ARC;
		cmd_ch.x = '0;
		cmd_ch.y = '0;
		cmd_ch.param_a = '0;
		cmd_ch.param_b = '0;
		cmd_ch.start_deg = '0;
		cmd_ch.end_deg = '0;
		vtx_ch.ready = 1'b0;
		pen_x = 0;
		pen_y = 0;
		send_idle = 0;
		recv_idle = 0;
		hold_left = 0;
		mismatches = 0;
		cmds_sent = 0;
		verts_seen = 0;
		foreach (mode_seen[i])
			mode_seen[i] = 0;

		add_row(mk_cmd(MODE_MOVE, 8388607, -8388608, 0, 0, 0, 0), 1);
		dir_vtx.push_back(mk_vtx(8388607, -8388608, PRIM_SINGLE, 1'b1));
		add_row(mk_cmd(MODE_DRAW, 8388607, 8388607, 0, 0, 0, 0), 1);
		dir_vtx.push_back(mk_vtx(8388607, -1, PRIM_SINGLE, 1'b1));
		add_row(mk_cmd(MODE_DRAW, -8388608, -8388608, 0, 0, 0, 0), 1);
		dir_vtx.push_back(mk_vtx(-1, -8388608, PRIM_SINGLE, 1'b1));
		add_row(mk_cmd(MODE_RECT, -8388608, 8388607, 8388607, -8388608, 0, 0), 4);
		dir_vtx.push_back(mk_vtx(-8388608, 8388607, PRIM_LLOOP, 1'b0));
		dir_vtx.push_back(mk_vtx(8388607, 8388607, PRIM_LLOOP, 1'b0));
		dir_vtx.push_back(mk_vtx(8388607, -8388608, PRIM_LLOOP, 1'b0));
		dir_vtx.push_back(mk_vtx(-8388608, -8388608, PRIM_LLOOP, 1'b1));
		add_row(mk_cmd(MODE_ARC, 0, 0, 25600, 0, 100, 50), 0);
		add_row(mk_cmd(MODE_FARC, 1234, -5678, 25600, 0, 6400, -6400), 1);
		dir_vtx.push_back(mk_vtx(1234, -5678, PRIM_TFAN, 1'b1));
		add_row(mk_cmd(MODE_ARC, 777, -333, 0, 0, 0, 0), 1);
		dir_vtx.push_back(mk_vtx(777, -333, PRIM_LSTRIP, 1'b1));
		add_row(mk_cmd(MODE_ARC, 0, 0, 25600, 0, 0, 5760), -1);
		add_row(mk_cmd(MODE_ARC, 2560, -2560, 12800, 0, 0, 23040), -1);
		add_row(mk_cmd(MODE_ARC, 0, 0, 8388607, 0, -32768, 32767), -1);
		add_row(mk_cmd(MODE_FARC, 100, 200, 51200, 0, 2880, 5760), -1);
		add_row(mk_cmd(MODE_ARC, 0, 0, -25600, 0, 1000, 1001), -1);
		add_row(mk_cmd(MODE_ARC, 0, 0, -25600, 0, 32767, 32767), -1);
		add_row(mk_cmd(MODE_CIRC, 8388607, 8388607, 8388607, 0, 0, 0), -1);
		add_row(mk_cmd(MODE_FCIRC, -8388608, 0, -8388608, 0, 0, 0), -1);
		add_row(mk_cmd(MODE_FCIRC, 0, 0, -12800, 0, 0, 0), -1);
		add_row(mk_cmd(MODE_WASHER, 0, 0, 12800, 25600, 0, 0), -1);
		add_row(mk_cmd(MODE_WASHER, -8388608, 8388607, -8388608, 8388607, 0, 0), -1);
		add_row(mk_cmd(MODE_MOVE, -5000, 5000, 0, 0, 0, 0), -1);
		add_row(mk_cmd(MODE_DRAW, 300, -300, 0, 0, 0, 0), -1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_cmd[r]) begin
			send_cmd(dir_cmd[r]);
			if (dir_cnt[r] < 0) begin
				expand_command(dir_cmd[r], vertex_q);
			end else begin
				expand_command(dir_cmd[r], scratch_q);
				scratch_q.delete();
				for (int k = 0; k < dir_cnt[r]; k++)
					vertex_q.push_back(dir_vtx.pop_front());
			end
		end

		run_random(100);
		send_idle = 69;
		run_random(95);
		send_idle = 0;
		recv_idle = 69;
		run_random(95);
		send_idle = 31;
		recv_idle = 31;
		run_random(95);
		send_idle = 0;
		recv_idle = 0;
		hold_left = 3000;
		for (int i = 0; i < 10; i++) begin
			draw_cmd_t cm;
			cm = mk_cmd(MODE_RECT, coord(), coord(), coord(), coord(), 0, 0);
			send_cmd(cm);
			expand_command(cm, vertex_q);
		end
		cmd_ch.valid <= 1'b0;

		while (vertex_q.size() != 0)
			@(posedge clk);
		wait_cycles = 200;
		repeat (wait_cycles) @(posedge clk);

		$display("Sent %0d commands (arc %0d, filled arc %0d, circle %0d, filled circle %0d,",
			cmds_sent, mode_seen[MODE_ARC], mode_seen[MODE_FARC], mode_seen[MODE_CIRC],
			mode_seen[MODE_FCIRC]);
		$display("washer %0d, rect %0d, move %0d, draw %0d); %0d vertices checked, %0d bad.",
			mode_seen[MODE_WASHER], mode_seen[MODE_RECT], mode_seen[MODE_MOVE],
			mode_seen[MODE_DRAW], verts_seen, mismatches);
		if (mismatches == 0)
			$display("tb_circle_arc_vertex_generator OK");
		else
			$display("tb_circle_arc_vertex_generator NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cav_pkg.sv
rtl/core/cav_cmd_if.sv
rtl/core/cav_vtx_if.sv
rtl/core/cav_ctrl.sv
rtl/core/cav_dpath.sv
rtl/core/circle_arc_vertex_generator.sv
tb/tb_circle_arc_vertex_generator.sv
